/* rtl/core/sst_pkg.sv */
// Shared types and constants for the shadowing symbol table.
package sst_pkg;

	localparam int DEPTH_DEF    = 256;
	localparam int KEY_BITS_DEF = 16;
	localparam int VAL_BITS     = 64;
	localparam int CMD_BITS     = 2;
	localparam int STAT_BITS    = 2;

	typedef enum logic [CMD_BITS-1:0] {
		CMD_DEFINE = 2'd0,
		CMD_GET    = 2'd1,
		CMD_SET    = 2'd2
	} cmd_t;

	typedef enum logic [STAT_BITS-1:0] {
		ST_OK        = 2'd0,
		ST_NOT_FOUND = 2'd1,
		ST_FULL      = 2'd2
	} status_t;

	typedef enum logic [1:0] {
		S_IDLE,
		S_DISPATCH,
		S_SCAN,
		S_DONE
	} state_t;

	typedef struct packed {
		logic [VAL_BITS-1:0] value;
		status_t             status;
	} result_t;

endpackage

/* rtl/core/sst_store.sv */
// Key and value memories: one write port, one registered read port.
module sst_store #(
	parameter int DEPTH    = sst_pkg::DEPTH_DEF,
	parameter int KEY_BITS = sst_pkg::KEY_BITS_DEF
) (
	input  logic                         clk,
	input  logic                         key_we,
	input  logic                         val_we,
	input  logic [$clog2(DEPTH)-1:0]     waddr,
	input  logic [KEY_BITS-1:0]          wkey,
	input  logic [sst_pkg::VAL_BITS-1:0] wval,
	input  logic [$clog2(DEPTH)-1:0]     raddr,
	output logic [KEY_BITS-1:0]          rkey,
	output logic [sst_pkg::VAL_BITS-1:0] rval
);
	import sst_pkg::*;

	logic [KEY_BITS-1:0] key_mem [DEPTH];
	logic [VAL_BITS-1:0] val_mem [DEPTH];

	always_ff @(posedge clk) begin
		if (key_we) begin
			key_mem[waddr] <= wkey;
		end
		rkey <= key_mem[raddr];
	end

	always_ff @(posedge clk) begin
		if (val_we) begin
			val_mem[waddr] <= wval;
		end
		rval <= val_mem[raddr];
	end

endmodule

/* rtl/core/sst_seq.sv */
// Command sequencer: entry count, top-down scan and the shared key comparator.
module sst_seq #(
	parameter int DEPTH    = sst_pkg::DEPTH_DEF,
	parameter int KEY_BITS = sst_pkg::KEY_BITS_DEF
) (
	input  logic                         clk,
	input  logic                         arst_n,
	input  logic                         in_valid,
	output logic                         in_ready,
	input  sst_pkg::cmd_t                in_cmd,
	input  logic [KEY_BITS-1:0]          in_key,
	input  logic [sst_pkg::VAL_BITS-1:0] in_val,
	input  logic                         out_free,
	output logic                         res_valid,
	output sst_pkg::result_t             res,
	output logic                         key_we,
	output logic                         val_we,
	output logic [$clog2(DEPTH)-1:0]     waddr,
	output logic [KEY_BITS-1:0]          wkey,
	output logic [sst_pkg::VAL_BITS-1:0] wval,
	output logic [$clog2(DEPTH)-1:0]     raddr,
	input  logic [KEY_BITS-1:0]          rkey,
	input  logic [sst_pkg::VAL_BITS-1:0] rval
);
	import sst_pkg::*;

	localparam int AW = $clog2(DEPTH);
	localparam int CW = $clog2(DEPTH + 1);

	state_t              state_q, state_d;
	cmd_t                cmd_q;
	logic [KEY_BITS-1:0] key_q;
	logic [VAL_BITS-1:0] val_q;
	logic [CW-1:0]       count_q, count_d;
	logic [AW-1:0]       addr_q, addr_d;
	result_t             res_q, res_d;
	logic [CW-1:0]       count_m1;
	logic                match;

	assign count_m1 = count_q - CW'(1);
	assign match    = (rkey == key_q);
	assign wkey     = key_q;
	assign wval     = val_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			count_q <= '0;
		end else begin
			state_q <= state_d;
			count_q <= count_d;
		end
	end

	always_ff @(posedge clk) begin
		if (in_valid && in_ready) begin
			cmd_q <= in_cmd;
			key_q <= in_key;
			val_q <= in_val;
		end
		addr_q <= addr_d;
		res_q  <= res_d;
	end

	always_comb begin
		state_d = state_q;
		count_d = count_q;
		addr_d  = addr_q;
		res_d   = res_q;
		key_we  = 1'b0;
		val_we  = 1'b0;
		waddr   = addr_q;
		// keep the read one entry ahead of the compare
		raddr   = addr_q - AW'(1);
		case (state_q)
			S_IDLE: begin
				if (in_valid) begin
					state_d = S_DISPATCH;
				end
			end
			S_DISPATCH: begin
				state_d = S_DONE;
				res_d   = '{value: '0, status: ST_OK};
				case (cmd_q)
					CMD_DEFINE: begin
						if (count_q == CW'(DEPTH)) begin
							res_d.status = ST_FULL;
						end else begin
							key_we      = 1'b1;
							val_we      = 1'b1;
							waddr       = count_q[AW-1:0];
							count_d     = count_q + CW'(1);
							res_d.value = val_q;
						end
					end
					CMD_GET, CMD_SET: begin
						if (count_q == '0) begin
							res_d.status = ST_NOT_FOUND;
						end else begin
							raddr   = count_m1[AW-1:0];
							addr_d  = count_m1[AW-1:0];
							state_d = S_SCAN;
						end
					end
					default: ;
				endcase
			end
			S_SCAN: begin
				if (match) begin
					state_d = S_DONE;
					if (cmd_q == CMD_SET) begin
						val_we      = 1'b1;
						res_d.value = val_q;
					end else begin
						res_d.value = rval;
					end
				end else if (addr_q == '0) begin
					state_d = S_DONE;
					res_d.status = ST_NOT_FOUND;
				end else begin
					addr_d = addr_q - AW'(1);
				end
			end
			S_DONE: begin
				if (out_free) begin
					state_d = S_IDLE;
				end
			end
			default: state_d = S_IDLE;
		endcase
	end

	assign in_ready  = (state_q == S_IDLE);
	assign res_valid = (state_q == S_DONE);
	assign res       = res_q;

endmodule

/* rtl/core/shadowing_symbol_table_top.sv */
// Top level of the shadowing symbol table: stream ports and output register.
//
// A stack-like variable table. Each slave transfer carries one command in
// s_tuser (define, get, set) with a key and a 64-bit value in s_tdata; each
// command gives exactly one master transfer with the value in m_tdata and the
// status (ok, not found, full) in m_tuser. Define pushes a new entry, get and
// set act on the newest entry whose key matches, scanning from the top down.
// Define writes its entry in the dispatch state unless the table is full;
// on a nonempty table, get and set go on to the scan state, which examines
// entries from the newest down to a match or to the oldest entry. One
// entry is compared per cycle by a single comparator against the registered
// read port of the key memory. Commands are handled one at a time; s_tready
// is high only while idle, so the next command waits for the last result.
// Reset empties the table (entry count zero); the memories are not cleared
// and need no clearing pass. A finished result waits in the output register
// while m_tready is low, and the next command may still be accepted; the
// sequencer holds its own result until the output register is free.
module shadowing_symbol_table_top #(
	parameter int DEPTH    = sst_pkg::DEPTH_DEF,
	parameter int KEY_BITS = sst_pkg::KEY_BITS_DEF,
	localparam int IN_BITS = ((KEY_BITS + sst_pkg::VAL_BITS + 7) / 8) * 8
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          s_tvalid,
	output logic                          s_tready,
	input  logic [IN_BITS-1:0]            s_tdata,  // key, value
	input  logic [sst_pkg::CMD_BITS-1:0]  s_tuser,  // command
	output logic                          m_tvalid,
	input  logic                          m_tready,
	output logic [sst_pkg::VAL_BITS-1:0]  m_tdata,  // result_value
	output logic [sst_pkg::STAT_BITS-1:0] m_tuser   // status
);
	import sst_pkg::*;

	localparam int AW = $clog2(DEPTH);

	logic                in_cmd_ok;
	cmd_t                in_cmd;
	logic [KEY_BITS-1:0] in_key;
	logic [VAL_BITS-1:0] in_val;
	logic                out_free;
	logic                res_valid;
	result_t             res;
	logic                load;
	logic                m_tvalid_q;
	result_t             m_res_q;

	logic                key_we, val_we;
	logic [AW-1:0]       waddr, raddr;
	logic [KEY_BITS-1:0] wkey, rkey;
	logic [VAL_BITS-1:0] wval, rval;

	assign in_cmd    = cmd_t'(s_tuser);
	assign in_key    = s_tdata[KEY_BITS-1:0];
	assign in_val    = s_tdata[KEY_BITS +: VAL_BITS];
	assign in_cmd_ok = s_tvalid;

	sst_seq #(
		.DEPTH    (DEPTH),
		.KEY_BITS (KEY_BITS)
	) u_seq (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_cmd_ok),
		.in_ready  (s_tready),
		.in_cmd    (in_cmd),
		.in_key    (in_key),
		.in_val    (in_val),
		.out_free  (out_free),
		.res_valid (res_valid),
		.res       (res),
		.key_we    (key_we),
		.val_we    (val_we),
		.waddr     (waddr),
		.wkey      (wkey),
		.wval      (wval),
		.raddr     (raddr),
		.rkey      (rkey),
		.rval      (rval)
	);

	sst_store #(
		.DEPTH    (DEPTH),
		.KEY_BITS (KEY_BITS)
	) u_store (
		.clk    (clk),
		.key_we (key_we),
		.val_we (val_we),
		.waddr  (waddr),
		.wkey   (wkey),
		.wval   (wval),
		.raddr  (raddr),
		.rkey   (rkey),
		.rval   (rval)
	);

	assign out_free = !m_tvalid_q || m_tready;
	assign load     = res_valid && out_free;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			m_tvalid_q <= 1'b0;
		end else if (load) begin
			m_tvalid_q <= 1'b1;
		end else if (m_tready) begin
			m_tvalid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (load) begin
			m_res_q <= res;
		end
	end

	assign m_tvalid = m_tvalid_q;
	assign m_tdata  = m_res_q.value;
	assign m_tuser  = m_res_q.status;

	// one command in flight at a time
	a_one_at_a_time: assert property (@(posedge clk) disable iff (!arst_n)
		s_tvalid && s_tready |=> !s_tready)
		else $error("command accepted while another is in flight");

	// a result blocked by the output register is held unchanged
	a_result_held: assert property (@(posedge clk) disable iff (!arst_n)
		res_valid && !out_free |=> res_valid && $stable(res))
		else $error("pending result lost or changed");

	// error results carry a zero value
	a_error_zero: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && m_tuser != ST_OK |-> m_tdata == '0)
		else $error("nonzero value on error result");

	// a loaded result shows up on the master side on the next cycle
	a_load_out: assert property (@(posedge clk) disable iff (!arst_n)
		load |=> m_tvalid && m_tdata == $past(res.value))
		else $error("result not presented after load");

endmodule
